[hdl/json_syntax_validator_macros.svh]
// Assertion macros for the JSON syntax validator checker.
// No dependencies.
`ifndef JSON_SYNTAX_VALIDATOR_MACROS_SVH
`define JSON_SYNTAX_VALIDATOR_MACROS_SVH
// implication checked every clock outside reset
`define JSV_ASSERT_IMP(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error("assertion failed");
// next-cycle implication checked outside reset
`define JSV_ASSERT_NXT(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

[hdl/jsv_pkg.sv]
// Shared types and constants for the JSON syntax validator.
// No dependencies.
package jsv_pkg;
  typedef enum logic [4:0] {
    M_ROOT, M_OBJ_FIRST, M_OBJ_KEY, M_COLON, M_VALUE, M_ARR_FIRST, M_AFTER,
    M_DONE, M_STR, M_ESC, M_HEX, M_LOW_BS, M_LOW_U, M_LOW_HEX, M_LIT,
    N_MINUS, N_ZERO, N_INT, N_DOT, N_FRAC, N_E, N_ESIGN, N_EXP
  } mode_t;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_VALID     = 3'd1;
  localparam logic [2:0] ST_MALFORMED = 3'd2;
  localparam logic [2:0] ST_DEEP      = 3'd3;
  localparam logic [2:0] ST_LONG      = 3'd4;

  localparam logic REG_MAX_DEPTH = 1'b0;
  localparam logic REG_MAX_STR   = 1'b1;

  localparam logic KIND_OBJ = 1'b0;
  localparam logic KIND_ARR = 1'b1;

  // stack cell control: push writes bit to cell 0 and shifts down, pop shifts up
  typedef struct packed {
    logic push;
    logic pop;
    logic kind;
  } stk_ctl_t;

  function automatic logic [7:0] lit_char(input logic [3:0] idx);
    case (idx)
      4'd0: lit_char = "t";
      4'd1: lit_char = "r";
      4'd2: lit_char = "u";
      4'd3: lit_char = "e";
      4'd4: lit_char = "f";
      4'd5: lit_char = "a";
      4'd6: lit_char = "l";
      4'd7: lit_char = "s";
      4'd8: lit_char = "e";
      4'd9: lit_char = "n";
      4'd10: lit_char = "u";
      4'd11: lit_char = "l";
      4'd12: lit_char = "l";
      default: lit_char = 8'h00;
    endcase
  endfunction

  function automatic logic is_ws(input logic [7:0] b);
    is_ws = (b == 8'h20) || (b == 8'h09) || (b == 8'h0D) || (b == 8'h0A);
  endfunction

  function automatic logic is_digit(input logic [7:0] b);
    is_digit = (b >= "0") && (b <= "9");
  endfunction
endpackage

[hdl/jsv_stack_cell.sv]
// One cell of the container-kind shift stack.
// Depends on jsv_pkg.
module jsv_stack_cell (
  input  logic              clk,
  input  jsv_pkg::stk_ctl_t ctl,
  input  logic              above,   // neighbor closer to top
  input  logic              below,   // neighbor farther from top
  output logic              kind
);
  always_ff @(posedge clk) begin
    if (ctl.push) begin
      kind <= above;
    end else if (ctl.pop) begin
      kind <= below;
    end
  end
endmodule

[hdl/jsv_stack.sv]
// Container stack built as a chain of shift cells; the top is cell 0.
// Depends on jsv_pkg, jsv_stack_cell.
module jsv_stack #(
  parameter int STACK_DEPTH = 64
) (
  input  logic              clk,
  input  jsv_pkg::stk_ctl_t ctl,
  output logic              top
);
  logic [STACK_DEPTH-1:0] cells;
  logic [STACK_DEPTH:0]   below_in;

  assign below_in = {cells[STACK_DEPTH-1], cells};

  for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
    jsv_stack_cell u_cell (
      .clk  (clk),
      .ctl  (ctl),
      .above((i == 0) ? ctl.kind : cells[(i == 0) ? 0 : i-1]),
      .below(below_in[i+1]),
      .kind (cells[i])
    );
  end

  assign top = cells[0];
endmodule

[hdl/json_syntax_validator.sv]
// JSON syntax validator: one status word per input word, one byte per cycle
// while the output is free (1 word/cycle); status is registered on acceptance.
// Container kinds live in a shift-register chain of cells, top at cell 0, so a
// push or pop happens in the same cycle as the byte's state update.
// Reset (rst, synchronous) clears parse state and loads max_depth=32,
// max_str_len=4096; stack cells are never read before being pushed.
module json_syntax_validator #(
  parameter int STACK_DEPTH = 64,
  parameter int LENGTH_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic        s_axis_tuser,   // [0] req_type
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [2:0] status, [7:3] zero
  output logic        m_axis_tlast,   // final_res
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data
);
  localparam int LW = LENGTH_BITS + 1;
  localparam logic [LW-1:0] LEN_CAP = {LW{1'b1}};
  localparam int LVW = $clog2(STACK_DEPTH + 2);
  localparam logic [LVW-1:0] STK_D = LVW'(STACK_DEPTH);
  // common width for the length limit compare
  localparam int CW = (LW > 16) ? LW : 16;

  logic [6:0]  max_depth;
  logic [15:0] max_str_len;

  jsv_pkg::mode_t mode, mode_next;
  logic [LVW-1:0] level, level_next;
  logic [LW-1:0]  dlen, dlen_next;
  logic [15:0]    hex_value, hex_value_next;
  logic [1:0]     hex_count, hex_count_next;
  logic [3:0]     lit, lit_next;
  logic           is_key, is_key_next;
  logic [2:0]     err, err_next;

  jsv_pkg::stk_ctl_t ctl;
  logic              top_kind;

  logic take;
  assign take = s_axis_tvalid && s_axis_tready;
  // output register frees whenever the result is taken or empty
  assign s_axis_tready = !m_axis_tvalid || m_axis_tready;
  assign cfg_ready = 1'b1;

  jsv_stack #(.STACK_DEPTH(STACK_DEPTH)) u_stack (
    .clk(clk), .ctl(ctl), .top(top_kind)
  );

  // combinational byte step
  always_comb begin
    logic [7:0]  b;
    logic [9:0]  lim;
    logic        dok;
    logic [3:0]  hd;
    logic        hv;
    logic [15:0] cp;
    logic [LW:0] sum;
    logic [1:0]  addn;
    logic        doadd;
    logic        after;
    b = s_axis_tdata;
    mode_next = mode; level_next = level; dlen_next = dlen;
    hex_value_next = hex_value; hex_count_next = hex_count;
    lit_next = lit; is_key_next = is_key; err_next = err;
    ctl = '0;
    addn = 2'd0; doadd = 1'b0; after = 1'b0;
    cp = 16'h0;
    sum = '0;
    lim = (10'(max_depth) > 10'(STACK_DEPTH)) ? 10'(STACK_DEPTH) : 10'(max_depth);
    dok = (10'(level) + 10'd1) <= lim;
    hv = 1'b1; hd = 4'h0;
    if (jsv_pkg::is_digit(b)) hd = 4'(b - "0");
    else if (b >= "a" && b <= "f") hd = 4'(b - "a" + 8'd10);
    else if (b >= "A" && b <= "F") hd = 4'(b - "A" + 8'd10);
    else hv = 1'b0;

    if (err == jsv_pkg::ST_OK) begin
      unique case (mode)
        jsv_pkg::M_ROOT: if (!jsv_pkg::is_ws(b)) begin
          if (b != "{") err_next = jsv_pkg::ST_MALFORMED;
          else if (!dok) err_next = jsv_pkg::ST_DEEP;
          else begin
            ctl = '{push: 1'b1, pop: 1'b0, kind: jsv_pkg::KIND_OBJ};
            level_next = level + 1'b1; mode_next = jsv_pkg::M_OBJ_FIRST;
          end
        end
        jsv_pkg::M_OBJ_FIRST, jsv_pkg::M_OBJ_KEY: if (!jsv_pkg::is_ws(b)) begin
          if (mode == jsv_pkg::M_OBJ_FIRST && b == "}") begin
            ctl.pop = 1'b1; level_next = level - 1'b1;
            mode_next = (level == 1) ? jsv_pkg::M_DONE : jsv_pkg::M_AFTER;
          end else if (b == "\"") begin
            is_key_next = 1'b1; dlen_next = '0; mode_next = jsv_pkg::M_STR;
          end else err_next = jsv_pkg::ST_MALFORMED;
        end
        jsv_pkg::M_COLON: if (!jsv_pkg::is_ws(b)) begin
          if (b != ":") err_next = jsv_pkg::ST_MALFORMED;
          else if (!dok) err_next = jsv_pkg::ST_DEEP;
          else mode_next = jsv_pkg::M_VALUE;
        end
        jsv_pkg::M_VALUE, jsv_pkg::M_ARR_FIRST: if (!jsv_pkg::is_ws(b)) begin
          if (mode == jsv_pkg::M_ARR_FIRST && b == "]") begin
            ctl.pop = 1'b1; level_next = level - 1'b1;
            mode_next = (level == 1) ? jsv_pkg::M_DONE : jsv_pkg::M_AFTER;
          end else if (mode == jsv_pkg::M_ARR_FIRST && !dok) begin
            err_next = jsv_pkg::ST_DEEP;
          end else if (b == "\"") begin
            is_key_next = 1'b0; dlen_next = '0; mode_next = jsv_pkg::M_STR;
          end else if (b == "{" || b == "[") begin
            if (level < STK_D) begin
              ctl = '{push: 1'b1, pop: 1'b0,
                      kind: (b == "[") ? jsv_pkg::KIND_ARR : jsv_pkg::KIND_OBJ};
            end
            level_next = level + 1'b1;
            mode_next = (b == "[") ? jsv_pkg::M_ARR_FIRST : jsv_pkg::M_OBJ_FIRST;
          end else if (b == "t") begin lit_next = 4'd1; mode_next = jsv_pkg::M_LIT;
          end else if (b == "f") begin lit_next = 4'd5; mode_next = jsv_pkg::M_LIT;
          end else if (b == "n") begin lit_next = 4'd10; mode_next = jsv_pkg::M_LIT;
          end else if (b == "-") mode_next = jsv_pkg::N_MINUS;
          else if (b == "0") mode_next = jsv_pkg::N_ZERO;
          else if (jsv_pkg::is_digit(b)) mode_next = jsv_pkg::N_INT;
          else err_next = jsv_pkg::ST_MALFORMED;
        end
        jsv_pkg::M_AFTER: after = 1'b1;
        jsv_pkg::M_DONE: if (!jsv_pkg::is_ws(b)) err_next = jsv_pkg::ST_MALFORMED;
        jsv_pkg::M_STR: begin
          if (b == "\"") begin
            mode_next = is_key ? jsv_pkg::M_COLON : jsv_pkg::M_AFTER;
            is_key_next = 1'b0;
          end else if (b < 8'h20) err_next = jsv_pkg::ST_MALFORMED;
          else if (b == "\\") mode_next = jsv_pkg::M_ESC;
          else begin doadd = 1'b1; addn = 2'd1; end
        end
        jsv_pkg::M_ESC: begin
          if (b == "\"" || b == "\\" || b == "/" || b == "b" || b == "f" ||
              b == "n" || b == "r" || b == "t") begin
            mode_next = jsv_pkg::M_STR; doadd = 1'b1; addn = 2'd1;
          end else if (b == "u") begin
            hex_value_next = '0; hex_count_next = '0; mode_next = jsv_pkg::M_HEX;
          end else err_next = jsv_pkg::ST_MALFORMED;
        end
        jsv_pkg::M_HEX, jsv_pkg::M_LOW_HEX: begin
          if (!hv) err_next = jsv_pkg::ST_MALFORMED;
          else begin
            cp = {hex_value[11:0], hd};
            hex_value_next = cp;
            if (hex_count != 2'd3) hex_count_next = hex_count + 1'b1;
            else if (mode == jsv_pkg::M_LOW_HEX) begin
              if (cp < 16'hDC00 || cp > 16'hDFFF) err_next = jsv_pkg::ST_MALFORMED;
              else begin mode_next = jsv_pkg::M_STR; doadd = 1'b1; addn = 2'd0; end
            end else if (cp >= 16'hD800 && cp <= 16'hDBFF) mode_next = jsv_pkg::M_LOW_BS;
            else if (cp >= 16'hDC00 && cp <= 16'hDFFF) err_next = jsv_pkg::ST_MALFORMED;
            else begin
              mode_next = jsv_pkg::M_STR; doadd = 1'b1;
              addn = (cp <= 16'h7F) ? 2'd1 : ((cp <= 16'h7FF) ? 2'd2 : 2'd3);
            end
          end
        end
        jsv_pkg::M_LOW_BS:
          if (b == "\\") mode_next = jsv_pkg::M_LOW_U;
          else err_next = jsv_pkg::ST_MALFORMED;
        jsv_pkg::M_LOW_U:
          if (b == "u") begin
            hex_value_next = '0; hex_count_next = '0; mode_next = jsv_pkg::M_LOW_HEX;
          end else err_next = jsv_pkg::ST_MALFORMED;
        jsv_pkg::M_LIT: begin
          if (lit > 4'd12 || b != jsv_pkg::lit_char(lit)) err_next = jsv_pkg::ST_MALFORMED;
          else if (lit == 4'd3 || lit == 4'd8 || lit == 4'd12) begin
            lit_next = '0; mode_next = jsv_pkg::M_AFTER;
          end else lit_next = lit + 1'b1;
        end
        jsv_pkg::N_MINUS:
          if (b == "0") mode_next = jsv_pkg::N_ZERO;
          else if (jsv_pkg::is_digit(b)) mode_next = jsv_pkg::N_INT;
          else err_next = jsv_pkg::ST_MALFORMED;
        jsv_pkg::N_ZERO, jsv_pkg::N_INT: begin
          if (jsv_pkg::is_digit(b)) begin
            if (mode == jsv_pkg::N_ZERO) err_next = jsv_pkg::ST_MALFORMED;
          end else if (b == ".") mode_next = jsv_pkg::N_DOT;
          else if (b == "e" || b == "E") mode_next = jsv_pkg::N_E;
          else begin mode_next = jsv_pkg::M_AFTER; after = 1'b1; end
        end
        jsv_pkg::N_DOT:
          if (jsv_pkg::is_digit(b)) mode_next = jsv_pkg::N_FRAC;
          else err_next = jsv_pkg::ST_MALFORMED;
        jsv_pkg::N_FRAC:
          if (b == "e" || b == "E") mode_next = jsv_pkg::N_E;
          else if (!jsv_pkg::is_digit(b)) begin
            mode_next = jsv_pkg::M_AFTER; after = 1'b1;
          end
        jsv_pkg::N_E:
          if (b == "+" || b == "-") mode_next = jsv_pkg::N_ESIGN;
          else if (jsv_pkg::is_digit(b)) mode_next = jsv_pkg::N_EXP;
          else err_next = jsv_pkg::ST_MALFORMED;
        jsv_pkg::N_ESIGN:
          if (jsv_pkg::is_digit(b)) mode_next = jsv_pkg::N_EXP;
          else err_next = jsv_pkg::ST_MALFORMED;
        jsv_pkg::N_EXP:
          if (!jsv_pkg::is_digit(b)) begin mode_next = jsv_pkg::M_AFTER; after = 1'b1; end
        default: err_next = jsv_pkg::ST_MALFORMED;
      endcase

      // value terminator handling, shared by M_AFTER and number ends
      if (after && !jsv_pkg::is_ws(b)) begin
        if ((top_kind == jsv_pkg::KIND_OBJ && b == "}") ||
            (top_kind == jsv_pkg::KIND_ARR && b == "]")) begin
          ctl.pop = 1'b1;
          level_next = (level == 0) ? level : level - 1'b1;
          mode_next = (level <= 1) ? jsv_pkg::M_DONE : jsv_pkg::M_AFTER;
        end else if (b == ",") begin
          if (top_kind == jsv_pkg::KIND_OBJ) mode_next = jsv_pkg::M_OBJ_KEY;
          else if (dok) mode_next = jsv_pkg::M_VALUE;
          else err_next = jsv_pkg::ST_DEEP;
        end else err_next = jsv_pkg::ST_MALFORMED;
      end

      // decoded-length accumulation (surrogate pair adds four)
      if (doadd) begin
        sum = {1'b0, dlen} + ((addn == 2'd0) ? (LW+1)'(4) : (LW+1)'(addn));
        dlen_next = sum[LW] ? LEN_CAP : sum[LW-1:0];
        if (CW'(dlen_next) > CW'(max_str_len) && err_next == jsv_pkg::ST_OK)
          err_next = jsv_pkg::ST_LONG;
      end
    end
    if (!take || s_axis_tuser) ctl = '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_depth <= 7'd32;
      max_str_len <= 16'd4096;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == jsv_pkg::REG_MAX_DEPTH) max_depth <= cfg_data[6:0];
      else max_str_len <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= jsv_pkg::M_ROOT; level <= '0; dlen <= '0; hex_value <= '0;
      hex_count <= '0; lit <= '0; is_key <= 1'b0; err <= jsv_pkg::ST_OK;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (m_axis_tready) m_axis_tvalid <= 1'b0;
      if (take) begin
        m_axis_tvalid <= 1'b1;
        m_axis_tlast <= s_axis_tuser;
        if (s_axis_tuser) begin
          m_axis_tdata <= {5'd0, (err != jsv_pkg::ST_OK) ? err :
                           ((mode == jsv_pkg::M_DONE) ? jsv_pkg::ST_VALID
                                                      : jsv_pkg::ST_MALFORMED)};
          mode <= jsv_pkg::M_ROOT; level <= '0; dlen <= '0; hex_value <= '0;
          hex_count <= '0; lit <= '0; is_key <= 1'b0; err <= jsv_pkg::ST_OK;
        end else begin
          m_axis_tdata <= {5'd0, err_next};
          mode <= mode_next; level <= level_next; dlen <= dlen_next;
          hex_value <= hex_value_next; hex_count <= hex_count_next;
          lit <= lit_next; is_key <= is_key_next; err <= err_next;
        end
      end
    end
  end
endmodule

[hdl/jsv_checker.sv]
// Port-level checker for the JSON syntax validator, bound to the top level.
// Depends on json_syntax_validator_macros.svh and jsv_pkg.
`include "json_syntax_validator_macros.svh"
module jsv_checker (
  input logic       clk,
  input logic       rst,
  input logic       s_axis_tvalid,
  input logic       s_axis_tready,
  input logic       s_axis_tuser,
  input logic       m_axis_tvalid,
  input logic       m_axis_tready,
  input logic [7:0] m_axis_tdata,
  input logic       m_axis_tlast
);
  `JSV_ASSERT_NXT(a_one_result, clk, rst, s_axis_tvalid && s_axis_tready, m_axis_tvalid)
  `JSV_ASSERT_NXT(a_last_follows, clk, rst, s_axis_tvalid && s_axis_tready && s_axis_tuser,
    m_axis_tlast)
  `JSV_ASSERT_IMP(a_status_range, clk, rst, m_axis_tvalid, m_axis_tdata[2:0] <= jsv_pkg::ST_LONG)
  `JSV_ASSERT_IMP(a_ok_not_final, clk, rst, m_axis_tvalid && m_axis_tlast,
    m_axis_tdata[2:0] != jsv_pkg::ST_OK)
  `JSV_ASSERT_IMP(a_hold, clk, rst, m_axis_tvalid && !m_axis_tready, !s_axis_tready)
endmodule

bind json_syntax_validator jsv_checker u_jsv_checker (
  .clk(clk), .rst(rst), .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
  .s_axis_tuser(s_axis_tuser), .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast)
);

[tb/testbench.sv]
// Self-checking bench for json_syntax_validator: random JSON documents, byte per word.
// Depends on jsv_pkg and the json_syntax_validator RTL.
module testbench;
  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = 8'h00;   // [7:0] data_byte
  logic        s_axis_tuser = 1'b0;    // [0] req_type
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;           // [2:0] status, [7:3] zero
  logic        m_axis_tlast;           // final_res
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_index = jsv_pkg::REG_MAX_DEPTH;
  logic [15:0] cfg_data = 16'h0000;

  json_syntax_validator u_top (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // one input word: req_type and document byte
  typedef struct packed {
    logic       eod;
    logic [7:0] data;
  } word_t;

  typedef struct packed {
    logic [2:0] st;
    logic       last;
  } status_t;

  word_t       word_q[$];      // words waiting for the driver
  status_t     status_q[$];    // expected status words, oldest first
  logic [7:0]  doc_q[$];       // document under construction
  int          send_pct = 0, recv_pct = 0, hold_left = 0;
  int          mismatches = 0;
  bit          in_took = 1'b0;

  // ---------------------------------------------------------------------------
  // Checker state: mirrors the parser's registers
  // ---------------------------------------------------------------------------
  int             depth_cfg = 32, strmax_cfg = 4096;
  jsv_pkg::mode_t pmode;
  bit             kinds[64];
  int             lvl, dlen, lit_pos;
  logic [15:0]    hval;
  int             hcnt;
  bit             is_key;
  logic [2:0]     err;
  string          lit_text = "truefalsenull";

  function automatic void clear_doc();
    pmode = jsv_pkg::M_ROOT; lvl = 0; dlen = 0; hval = 0; hcnt = 0;
    lit_pos = 0; is_key = 0; err = jsv_pkg::ST_OK;
    foreach (kinds[i]) kinds[i] = jsv_pkg::KIND_OBJ;
  endfunction

  function automatic bit space(logic [7:0] b);
    return b == 8'h20 || b == 8'h09 || b == 8'h0d || b == 8'h0a;
  endfunction

  function automatic bit digit(logic [7:0] b);
    return b >= 8'h30 && b <= 8'h39;
  endfunction

  function automatic void flag(logic [2:0] c);
    if (err == jsv_pkg::ST_OK) err = c;
  endfunction

  // level check for a new value; limit is min(max_depth, stack size)
  function automatic bit room();
    int lim;
    lim = (depth_cfg > 64) ? 64 : depth_cfg;
    if (lvl + 1 <= lim) return 1'b1;
    flag(jsv_pkg::ST_DEEP);
    return 1'b0;
  endfunction

  function automatic void grow(int n);
    dlen = dlen + n;
    if (dlen > 131071) dlen = 131071;  // counter saturates at 17 bits
    if (dlen > strmax_cfg) flag(jsv_pkg::ST_LONG);
  endfunction

  function automatic void push_kind(bit k);
    if (lvl < 64) kinds[lvl] = k;
    lvl++;
  endfunction

  function automatic void close_level();
    if (lvl > 0) lvl--;
    pmode = (lvl == 0) ? jsv_pkg::M_DONE : jsv_pkg::M_AFTER;
  endfunction

  function automatic bit top_kind();
    int i;
    i = (lvl == 0) ? 0 : lvl - 1;
    if (i > 63) i = 63;
    return kinds[i];
  endfunction

  function automatic void open_str(bit key);
    is_key = key; dlen = 0; pmode = jsv_pkg::M_STR;
  endfunction

  function automatic void open_value(logic [7:0] b);
    if (b == "\"") open_str(1'b0);
    else if (b == "{") begin push_kind(jsv_pkg::KIND_OBJ); pmode = jsv_pkg::M_OBJ_FIRST; end
    else if (b == "[") begin push_kind(jsv_pkg::KIND_ARR); pmode = jsv_pkg::M_ARR_FIRST; end
    else if (b == "t") begin lit_pos = 1; pmode = jsv_pkg::M_LIT; end
    else if (b == "f") begin lit_pos = 5; pmode = jsv_pkg::M_LIT; end
    else if (b == "n") begin lit_pos = 10; pmode = jsv_pkg::M_LIT; end
    else if (b == "-") pmode = jsv_pkg::N_MINUS;
    else if (b == "0") pmode = jsv_pkg::N_ZERO;
    else if (b >= "1" && b <= "9") pmode = jsv_pkg::N_INT;
    else flag(jsv_pkg::ST_MALFORMED);
  endfunction

  function automatic void after_val(logic [7:0] b);
    bit k;
    k = top_kind();
    if (space(b)) return;
    if ((k == jsv_pkg::KIND_OBJ && b == "}") || (k == jsv_pkg::KIND_ARR && b == "]"))
      close_level();
    else if (b == ",") begin
      if (k == jsv_pkg::KIND_OBJ) pmode = jsv_pkg::M_OBJ_KEY;
      else if (room()) pmode = jsv_pkg::M_VALUE;
    end else flag(jsv_pkg::ST_MALFORMED);
  endfunction

  function automatic void hex_in(logic [7:0] b);
    int d;
    if (digit(b)) d = b - "0";
    else if (b >= "a" && b <= "f") d = b - "a" + 10;
    else if (b >= "A" && b <= "F") d = b - "A" + 10;
    else begin flag(jsv_pkg::ST_MALFORMED); return; end
    hval = {hval[11:0], 4'(d)};
    if (hcnt < 3) begin hcnt++; return; end
    if (pmode == jsv_pkg::M_LOW_HEX) begin
      if (hval < 16'hdc00 || hval > 16'hdfff) begin flag(jsv_pkg::ST_MALFORMED); return; end
      pmode = jsv_pkg::M_STR;
      grow(4);
    end else if (hval >= 16'hd800 && hval <= 16'hdbff) pmode = jsv_pkg::M_LOW_BS;
    else if (hval >= 16'hdc00 && hval <= 16'hdfff) flag(jsv_pkg::ST_MALFORMED);
    else begin
      pmode = jsv_pkg::M_STR;
      grow(hval <= 16'h7f ? 1 : (hval <= 16'h7ff ? 2 : 3));
    end
  endfunction

  function automatic void num_end(logic [7:0] b);
    pmode = jsv_pkg::M_AFTER;
    after_val(b);
  endfunction

  function automatic void parse_byte(logic [7:0] b);
    case (pmode)
      jsv_pkg::M_ROOT: if (!space(b)) begin
        if (b != "{") flag(jsv_pkg::ST_MALFORMED);
        else if (room()) begin
          push_kind(jsv_pkg::KIND_OBJ); pmode = jsv_pkg::M_OBJ_FIRST;
        end
      end
      jsv_pkg::M_OBJ_FIRST, jsv_pkg::M_OBJ_KEY: if (!space(b)) begin
        if (pmode == jsv_pkg::M_OBJ_FIRST && b == "}") close_level();
        else if (b == "\"") open_str(1'b1);
        else flag(jsv_pkg::ST_MALFORMED);
      end
      jsv_pkg::M_COLON: if (!space(b)) begin
        if (b != ":") flag(jsv_pkg::ST_MALFORMED);
        else if (room()) pmode = jsv_pkg::M_VALUE;
      end
      jsv_pkg::M_VALUE: if (!space(b)) open_value(b);
      jsv_pkg::M_ARR_FIRST: if (!space(b)) begin
        if (b == "]") close_level();
        else if (room()) open_value(b);
      end
      jsv_pkg::M_AFTER: after_val(b);
      jsv_pkg::M_DONE: if (!space(b)) flag(jsv_pkg::ST_MALFORMED);
      jsv_pkg::M_STR: begin
        if (b == "\"") begin
          pmode = is_key ? jsv_pkg::M_COLON : jsv_pkg::M_AFTER; is_key = 0;
        end
        else if (b < 8'h20) flag(jsv_pkg::ST_MALFORMED);
        else if (b == "\\") pmode = jsv_pkg::M_ESC;
        else grow(1);
      end
      jsv_pkg::M_ESC: begin
        if (b == "\"" || b == "\\" || b == "/" || b == "b" || b == "f" ||
            b == "n" || b == "r" || b == "t") begin
          pmode = jsv_pkg::M_STR; grow(1);
        end else if (b == "u") begin hval = 0; hcnt = 0; pmode = jsv_pkg::M_HEX; end
        else flag(jsv_pkg::ST_MALFORMED);
      end
      jsv_pkg::M_HEX, jsv_pkg::M_LOW_HEX: hex_in(b);
      jsv_pkg::M_LOW_BS: if (b == "\\") pmode = jsv_pkg::M_LOW_U;
                         else flag(jsv_pkg::ST_MALFORMED);
      jsv_pkg::M_LOW_U: if (b == "u") begin
                          hval = 0; hcnt = 0; pmode = jsv_pkg::M_LOW_HEX;
                        end
                        else flag(jsv_pkg::ST_MALFORMED);
      jsv_pkg::M_LIT: begin
        if (lit_pos >= 13 || b != lit_text[lit_pos]) flag(jsv_pkg::ST_MALFORMED);
        else if (lit_pos == 3 || lit_pos == 8 || lit_pos == 12) begin
          lit_pos = 0; pmode = jsv_pkg::M_AFTER;
        end else lit_pos++;
      end
      jsv_pkg::N_MINUS: if (b == "0") pmode = jsv_pkg::N_ZERO;
                        else if (digit(b)) pmode = jsv_pkg::N_INT;
                        else flag(jsv_pkg::ST_MALFORMED);
      jsv_pkg::N_ZERO, jsv_pkg::N_INT: begin
        if (digit(b)) begin
          if (pmode == jsv_pkg::N_ZERO) flag(jsv_pkg::ST_MALFORMED);  // no leading zeros
        end else if (b == ".") pmode = jsv_pkg::N_DOT;
        else if (b == "e" || b == "E") pmode = jsv_pkg::N_E;
        else num_end(b);
      end
      jsv_pkg::N_DOT: if (digit(b)) pmode = jsv_pkg::N_FRAC;
                      else flag(jsv_pkg::ST_MALFORMED);
      jsv_pkg::N_FRAC: if (!digit(b)) begin
        if (b == "e" || b == "E") pmode = jsv_pkg::N_E; else num_end(b);
      end
      jsv_pkg::N_E: if (b == "+" || b == "-") pmode = jsv_pkg::N_ESIGN;
                    else if (digit(b)) pmode = jsv_pkg::N_EXP;
                    else flag(jsv_pkg::ST_MALFORMED);
      jsv_pkg::N_ESIGN: if (digit(b)) pmode = jsv_pkg::N_EXP;
                        else flag(jsv_pkg::ST_MALFORMED);
      jsv_pkg::N_EXP: if (!digit(b)) num_end(b);
      default: flag(jsv_pkg::ST_MALFORMED);
    endcase
  endfunction

  // expected status word for one accepted input word
  function automatic status_t predict_status(word_t w);
    status_t r;
    if (w.eod) begin
      if (err != jsv_pkg::ST_OK) r.st = err;
      else r.st = (pmode == jsv_pkg::M_DONE) ? jsv_pkg::ST_VALID : jsv_pkg::ST_MALFORMED;
      r.last = 1'b1;
      clear_doc();
    end else begin
      if (err == jsv_pkg::ST_OK) parse_byte(w.data);
      r.st = err;
      r.last = 1'b0;
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Document generator
  // ---------------------------------------------------------------------------
  function automatic void put(logic [7:0] b);
    doc_q.insert(doc_q.size(), b);
  endfunction

  function automatic void put_text(string s);
    foreach (s[i]) put(s[i]);
  endfunction

  function automatic void put_ws();
    string pool;
    pool = " \t\r\n";
    if ($urandom_range(2) == 0)
      repeat ($urandom_range(1, 2)) put(pool[$urandom_range(3)]);
  endfunction

  function automatic void put_hex(logic [15:0] v);
    logic [3:0] n;
    for (int i = 3; i >= 0; i--) begin
      n = v[i*4 +: 4];
      if (n < 10) put(8'h30 + n);
      else put(8'(($urandom_range(1) ? 8'h41 : 8'h61) + n - 8'd10));
    end
  endfunction

  function automatic void put_str();
    int n;
    string esc;
    esc = "\"\\/bfnrt";
    n = ($urandom_range(7) == 0) ? $urandom_range(8, 24) : $urandom_range(0, 5);
    put("\"");
    repeat (n) begin
      case ($urandom_range(9))
        0, 1, 2, 3: put(8'($urandom_range(8'h5d, 8'h7f)));  // above the backslash
        4: put(8'($urandom_range(8'h23, 8'h5b)));
        5: put(8'($urandom_range(8'h80, 8'hff)));
        6: begin put("\\"); put(esc[$urandom_range(7)]); end
        7: begin put_text("\\u"); put_hex(16'($urandom_range(16'hffff))); end
        8: begin
          put_text("\\u"); put_hex(16'($urandom_range(16'hd800, 16'hdbff)));
          put_text("\\u"); put_hex(16'($urandom_range(16'hdc00, 16'hdfff)));
        end
        default: begin
          put_text("\\u");
          case ($urandom_range(2))
            0: put_hex(16'($urandom_range(16'h7f)));
            1: put_hex(16'($urandom_range(16'h80, 16'h7ff)));
            default: put_hex(16'($urandom_range(16'hdc00, 16'hdfff)));  // stray low half
          endcase
        end
      endcase
    end
    put("\"");
  endfunction

  function automatic void put_num();
    if ($urandom_range(2) == 0) put("-");
    if ($urandom_range(3) == 0) put("0");
    else begin
      put(8'($urandom_range("1", "9")));
      repeat ($urandom_range(2)) put(8'($urandom_range("0", "9")));
    end
    if ($urandom_range(2) == 0) begin
      put(".");
      repeat ($urandom_range(1, 3)) put(8'($urandom_range("0", "9")));
    end
    if ($urandom_range(3) == 0) begin
      put($urandom_range(1) ? "e" : "E");
      case ($urandom_range(2))
        0: put("+");
        1: put("-");
        default: ;
      endcase
      repeat ($urandom_range(1, 2)) put(8'($urandom_range("0", "9")));
    end
  endfunction

  function automatic void put_val(int d);
    int pick;
    pick = (d >= 4) ? $urandom_range(2, 4) : $urandom_range(4);
    case (pick)
      0: put_obj(d);
      1: put_arr(d);
      2: put_str();
      3: put_num();
      default: case ($urandom_range(2))
        0: put_text("true");
        1: put_text("false");
        default: put_text("null");
      endcase
    endcase
  endfunction

  function automatic void put_obj(int d);
    put("{"); put_ws();
    for (int i = $urandom_range(3); i > 0; i--) begin
      put_ws(); put_str(); put_ws(); put(":"); put_ws();
      put_val(d + 1); put_ws();
      if (i > 1) put(",");
    end
    put("}");
  endfunction

  function automatic void put_arr(int d);
    put("["); put_ws();
    for (int i = $urandom_range(3); i > 0; i--) begin
      put_ws(); put_val(d + 1); put_ws();
      if (i > 1) put(",");
    end
    put("]");
  endfunction

  // root object holding a chain of arrays, innermost value at level k+1
  function automatic void put_deep(int k);
    put_text("{\"d\":");
    repeat (k - 1) put("[");
    put("1");
    repeat (k - 1) put("]");
    put("}");
  endfunction

  // queue one document (well formed, damaged, or noise) plus its end word
  function automatic void queue_doc();
    int r;
    doc_q.delete();
    r = $urandom_range(99);
    if (r < 8) repeat ($urandom_range(1, 10)) put(8'($urandom_range(255)));
    else begin
      put_ws();
      if (r < 20) put_deep($urandom_range(1, 66));
      else put_obj(1);
      put_ws();
      if (r >= 85 && doc_q.size() > 1)
        doc_q[$urandom_range(doc_q.size() - 1)] = 8'($urandom_range(255));
      else if (r >= 80) doc_q = doc_q[0:$urandom_range(doc_q.size() - 1)];
      else if (r >= 78) put(8'($urandom_range(255)));  // trailing junk
    end
    foreach (doc_q[i]) word_q.insert(word_q.size(), word_t'{1'b0, doc_q[i]});
    word_q.insert(word_q.size(), word_t'{1'b1, 8'($urandom_range(255))});
  endfunction

  // ---------------------------------------------------------------------------
  // Driver, receiver and monitor
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || in_took) begin
      if (word_q.size() > 0 && $urandom_range(99) >= send_pct) begin
        s_axis_tvalid <= 1'b1;
        {s_axis_tuser, s_axis_tdata} <= word_q.pop_front();
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // receiver; a long hold-off is counted down here
  always @(negedge clk) begin
    if (hold_left > 0) begin
      m_axis_tready <= 1'b0;
      hold_left <= hold_left - 1;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_pct);
    end
  end

  always @(posedge clk) begin
    status_t got, want;
    in_took = 1'b0;
    if (!rst) begin
      // results first: a word accepted this edge cannot have its result yet
      if (m_axis_tvalid && m_axis_tready) begin
        got = '{m_axis_tdata[2:0], m_axis_tlast};
        if (status_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected status word: status %0d last %0d", got.st, got.last);
        end else begin
          want = status_q.pop_front();
          if (got.st !== want.st || got.last !== want.last || m_axis_tdata[7:3] !== 5'd0) begin
            mismatches++;
            if (mismatches <= 10)
              $display("status mismatch: expected %0d/%0d got %0d/%0d (tdata %h)",
                       want.st, want.last, got.st, got.last, m_axis_tdata);
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        in_took = 1'b1;
        status_q.insert(status_q.size(), predict_status('{s_axis_tuser, s_axis_tdata}));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  task automatic write_reg(logic idx, logic [15:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx == jsv_pkg::REG_MAX_DEPTH) depth_cfg = val[6:0];
    else strmax_cfg = val;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic drain();
    while (word_q.size() > 0 || s_axis_tvalid || status_q.size() > 0) @(posedge clk);
    repeat (5) @(posedge clk);
  endtask

  initial begin
    int depths[6] = '{32, 1, 64, 2, 3, 64};
    int lens[6] = '{4096, 0, 65535, 5, 20, 3};
    int mark;
    clear_doc();
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: object, array, number, true and a surrogate pair escape, then a bad root
    put_text("{\"a\":[-0.5e+1,true,\"\\ud83d\\ude00\"]}");
    foreach (doc_q[i]) word_q.insert(word_q.size(), word_t'{1'b0, doc_q[i]});
    word_q.insert(word_q.size(), word_t'{1'b1, 8'hff});
    word_q.insert(word_q.size(), word_t'{1'b0, "["});
    word_q.insert(word_q.size(), word_t'{1'b1, 8'h00});
    drain();

    for (int p = 0; p < 6; p++) begin
      write_reg(jsv_pkg::REG_MAX_DEPTH, 16'(depths[p]));
      write_reg(jsv_pkg::REG_MAX_STR, 16'(lens[p]));
      send_pct = (p < 2) ? 24 : (p < 4) ? 72 : 0;
      recv_pct = (p < 2) ? 72 : (p < 4) ? 24 : 0;
      mark = 0;
      while (mark < 155) begin
        mark += word_q.size();
        queue_doc();
        mark = mark + word_q.size() - mark;
      end
      // long receiver stall while the sender keeps offering words
      if (p == 4) begin
        @(posedge clk);
        hold_left = 300;
      end
      drain();
    end

    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("simulation failed");
    $finish;
  end
endmodule
